// ----- design/dnf_pkg.sv -----
package dnf_pkg;

	localparam int DEPTH_DEF    = 4096;
	localparam int KEY_BITS_DEF = 64;

	localparam int CNT_W      = 13;
	localparam int OP_W       = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int EVICT_W    = 8;
	localparam int MARKS_W    = 7;
	localparam int GROW_W     = 12;
	localparam int SHRINK_W   = 10;
	localparam int FRAC_W     = 10;

	// unity scale in the 10 fraction bit format
	localparam logic [GROW_W-1:0] FIX_ONE = GROW_W'(1024);

	// opcodes on the input channel
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
	localparam logic [OP_W-1:0] OP_MARK   = 3'd2;
	localparam logic [OP_W-1:0] OP_ADJUST = 3'd3;
	localparam logic [OP_W-1:0] OP_INIT   = 3'd4;

	// item classes handed from front to back
	localparam logic [2:0] CL_QUERY  = 3'd0;
	localparam logic [2:0] CL_ADD    = 3'd1;
	localparam logic [2:0] CL_MARK   = 3'd2;
	localparam logic [2:0] CL_ADJUST = 3'd3;
	localparam logic [2:0] CL_INIT   = 3'd4;
	localparam logic [2:0] CL_NONE   = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CAP   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CAP   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_MARKS = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GROW      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EVICT_LIM = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_KEY  = 4'd7;

	typedef struct packed {
		logic [CNT_W-1:0]      min_cap;
		logic [CNT_W-1:0]      max_cap;
		logic [CNT_W-1:0]      init_cap;
		logic [MARKS_W-1:0]    exp_marks;
		logic [GROW_W-1:0]     grow;
		logic [SHRINK_W-1:0]   shrink;
		logic [EVICT_W-1:0]    evict_lim;
		logic [CFG_DATA_W-1:0] mark_key;
	} cfg_t;

endpackage

// ----- design/dnf_front.sv -----
module dnf_front #(
	parameter int KEY_BITS = dnf_pkg::KEY_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [dnf_pkg::OP_W-1:0]  opcode,
	input  logic [KEY_BITS-1:0]       entry_key,
	output logic                      q_valid,
	output logic [2:0]                q_cls,
	output logic [KEY_BITS-1:0]       q_key,
	input  logic                      q_take
);
	import dnf_pkg::*;

	logic [2:0]          cls_q [2];
	logic [KEY_BITS-1:0] key_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;
	logic [2:0]          cls_in;
	logic                push;
	logic                pop;

	always_comb begin
		unique case (opcode)
			OP_QUERY:  cls_in = CL_QUERY;
			OP_ADD:    cls_in = CL_ADD;
			OP_MARK:   cls_in = CL_MARK;
			OP_ADJUST: cls_in = CL_ADJUST;
			OP_INIT:   cls_in = CL_INIT;
			default:   cls_in = CL_NONE;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_take && q_valid;
	assign q_cls    = cls_q[rd_ptr_q];
	assign q_key    = key_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cls_q[wr_ptr_q] <= cls_in;
			key_q[wr_ptr_q] <= entry_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- design/dnf_back.sv -----
module dnf_back #(
	parameter int DEPTH    = dnf_pkg::DEPTH_DEF,
	parameter int KEY_BITS = dnf_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dnf_pkg::cfg_t               cfg,
	input  logic                        recount_set,
	input  logic                        q_valid,
	input  logic [2:0]                  q_cls,
	input  logic [KEY_BITS-1:0]         q_key,
	output logic                        q_take,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [dnf_pkg::CNT_W-1:0]   live_count,
	output logic [dnf_pkg::CNT_W-1:0]   marks_held,
	output logic [dnf_pkg::CNT_W-1:0]   capacity_now,
	output logic [dnf_pkg::EVICT_W-1:0] evicted
);
	import dnf_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int LW   = $clog2(DEPTH + 1);
	localparam int CMPW = (LW > CNT_W) ? LW : CNT_W;
	localparam int PW   = CNT_W + GROW_W;
	localparam int CW   = PW - FRAC_W;
	localparam logic [CMPW-1:0]  DEPTH_W   = CMPW'(DEPTH);
	localparam logic [LW-1:0]    DEPTH_L   = LW'(DEPTH);
	localparam logic [AW-1:0]    LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CAP_RST   = (DEPTH < 1024) ? CNT_W'(DEPTH) : CNT_W'(1024);
	localparam logic [CMPW-1:0]  LEAST_RST = CMPW'(13'h1FFF);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_RC       = 5'd1;
	localparam logic [4:0] S_DISP     = 5'd2;
	localparam logic [4:0] S_SCAN     = 5'd3;
	localparam logic [4:0] S_SH_RD    = 5'd4;
	localparam logic [4:0] S_SH_WR    = 5'd5;
	localparam logic [4:0] S_PUSH_CHK = 5'd6;
	localparam logic [4:0] S_POP_RD   = 5'd7;
	localparam logic [4:0] S_POP_CMP  = 5'd8;
	localparam logic [4:0] S_PUSH_WR  = 5'd9;
	localparam logic [4:0] S_REC      = 5'd10;
	localparam logic [4:0] S_EV_SET   = 5'd11;
	localparam logic [4:0] S_EV_CHK   = 5'd12;
	localparam logic [4:0] S_CLAMP    = 5'd13;
	localparam logic [4:0] S_INIT     = 5'd14;
	localparam logic [4:0] S_DONE     = 5'd15;

	function automatic logic [AW-1:0] ring(input logic [AW-1:0] base, input logic [LW-1:0] off);
		logic [LW:0] s;
		s = (LW+1)'(base) + (LW+1)'(off);
		if (s >= (LW+1)'(DEPTH))
			s = s - (LW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] hold_cap(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (CMPW'(r) > DEPTH_W)
			r = DEPTH_W[CNT_W-1:0];
		if (r == '0)
			r = CNT_W'(1);
		return r;
	endfunction

	logic [KEY_BITS-1:0] mem [DEPTH];
	logic [KEY_BITS-1:0] rdata_s1;

	logic [4:0]          state_q;
	logic [2:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AW-1:0]       head_q;
	logic [LW-1:0]       len_q;
	logic [LW-1:0]       marks_q;
	logic [CNT_W-1:0]    cap_q;
	logic                any_q;
	logic [CMPW-1:0]     least_q;
	logic [CMPW-1:0]     most_q;
	logic                recount_q;
	logic                found_q;
	logic [EVICT_W-1:0]  evicted_q;
	logic [EVICT_W-1:0]  ev_target_q;
	logic                forced_q;
	logic [LW-1:0]       rd_i_q;
	logic                cmp_v_s1;
	logic [LW-1:0]       cmp_i_s1;
	logic [LW-1:0]       rcnt_q;
	logic [LW-1:0]       sh_i_q;
	logic [PW-1:0]       prod_s1;
	logic [MARKS_W-1:0]  init_left_q;

	logic                out_valid_q;
	logic                found_o_q;
	logic [CNT_W-1:0]    live_o_q;
	logic [CNT_W-1:0]    marks_o_q;
	logic [CNT_W-1:0]    cap_o_q;
	logic [EVICT_W-1:0]  evicted_o_q;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [KEY_BITS-1:0] wr_data;

	logic [KEY_BITS-1:0] mkey;
	logic [KEY_BITS-1:0] push_val;
	logic [AW-1:0]       tail_slot;
	logic [LW-1:0]       sh_nx;
	logic                match_key;
	logic                match_mark;
	logic                out_free;
	logic [GROW_W-1:0]   fsel;
	logic [CNT_W-1:0]    cap_new;
	logic [EVICT_W-1:0]  tgt;
	logic [MARKS_W-1:0]  init_n;
	logic [CMPW-1:0]     marks_c;

	assign mkey       = cfg.mark_key[KEY_BITS-1:0];
	assign push_val   = (op_q == CL_MARK) ? mkey : key_q;
	assign tail_slot  = ring(head_q, len_q);
	assign sh_nx      = sh_i_q + LW'(1);
	assign match_key  = (rdata_s1 == key_q);
	assign match_mark = (rdata_s1 == mkey);
	assign out_free   = !out_valid_q || !out_stall;
	assign q_take     = (state_q == S_IDLE) && q_valid && out_free;
	assign marks_c    = CMPW'(marks_q);
	assign init_n     = (CMPW'(cfg.exp_marks) > DEPTH_W) ? DEPTH_W[MARKS_W-1:0] : cfg.exp_marks;

	// shrink when nothing was recorded or every count ran above the expected one
	always_comb begin
		if (!any_q || least_q > CMPW'(cfg.exp_marks))
			fsel = GROW_W'(cfg.shrink);
		else if (most_q < CMPW'(cfg.exp_marks))
			fsel = cfg.grow;
		else
			fsel = FIX_ONE;
	end

	always_comb begin
		logic [CW-1:0] c;
		c = prod_s1[PW-1:FRAC_W];
		if (c > CW'(cfg.max_cap))
			c = CW'(cfg.max_cap);
		if (c < CW'(cfg.min_cap))
			c = CW'(cfg.min_cap);
		cap_new = hold_cap(c[CNT_W-1:0]);
	end

	always_comb begin
		logic [CMPW-1:0] excess;
		logic [CMPW:0]   sum;
		logic [EVICT_W-1:0] n;
		excess = (CMPW'(len_q) > CMPW'(cap_q)) ? (CMPW'(len_q) - CMPW'(cap_q)) : '0;
		sum    = (CMPW+1)'(excess) + (CMPW+1)'(evicted_q);
		n      = (sum > (CMPW+1)'(cfg.evict_lim)) ? cfg.evict_lim : sum[EVICT_W-1:0];
		tgt    = (n < evicted_q) ? evicted_q : n;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = tail_slot;
		wr_data = push_val;
		unique case (state_q)
			S_RC, S_SCAN: begin
				rd_en   = (rd_i_q < len_q);
				rd_addr = ring(head_q, rd_i_q);
			end
			S_SH_RD: begin
				rd_en   = 1'b1;
				rd_addr = ring(head_q, sh_nx);
				// last step: the moved key lands at the tail
				if (!(sh_nx < len_q)) begin
					wr_en   = 1'b1;
					wr_addr = ring(head_q, len_q - LW'(1));
					wr_data = key_q;
				end
			end
			S_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = ring(head_q, sh_i_q);
				wr_data = rdata_s1;
			end
			S_POP_RD: begin
				rd_en = 1'b1;
			end
			S_PUSH_WR: begin
				wr_en = 1'b1;
			end
			S_INIT: begin
				wr_en   = (init_left_q != '0);
				wr_data = mkey;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= CL_NONE;
			key_q       <= '0;
			head_q      <= '0;
			len_q       <= '0;
			marks_q     <= '0;
			cap_q       <= CAP_RST;
			any_q       <= 1'b0;
			least_q     <= LEAST_RST;
			most_q      <= '0;
			recount_q   <= 1'b0;
			found_q     <= 1'b0;
			evicted_q   <= '0;
			ev_target_q <= '0;
			forced_q    <= 1'b0;
			rd_i_q      <= '0;
			cmp_v_s1    <= 1'b0;
			cmp_i_s1    <= '0;
			rcnt_q      <= '0;
			sh_i_q      <= '0;
			prod_s1     <= '0;
			init_left_q <= '0;
			out_valid_q <= 1'b0;
			found_o_q   <= 1'b0;
			live_o_q    <= '0;
			marks_o_q   <= '0;
			cap_o_q     <= '0;
			evicted_o_q <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (q_take) begin
						op_q      <= q_cls;
						key_q     <= q_key;
						found_q   <= 1'b0;
						evicted_q <= '0;
						forced_q  <= 1'b0;
						rd_i_q    <= '0;
						cmp_v_s1  <= 1'b0;
						rcnt_q    <= '0;
						state_q   <= recount_q ? S_RC : S_DISP;
					end
				end
				S_RC: begin
					// marker key changed: count markers again
					if (cmp_v_s1 && match_mark)
						rcnt_q <= rcnt_q + LW'(1);
					if (rd_i_q < len_q) begin
						cmp_v_s1 <= 1'b1;
						rd_i_q   <= rd_i_q + LW'(1);
					end else begin
						cmp_v_s1 <= 1'b0;
						if (!cmp_v_s1) begin
							marks_q   <= rcnt_q;
							recount_q <= 1'b0;
							state_q   <= S_DISP;
						end
					end
				end
				S_DISP: begin
					rd_i_q   <= '0;
					cmp_v_s1 <= 1'b0;
					unique case (op_q)
						CL_QUERY, CL_ADD: begin
							if (len_q == '0)
								state_q <= (op_q == CL_ADD) ? S_PUSH_CHK : S_DONE;
							else
								state_q <= S_SCAN;
						end
						CL_MARK: begin
							state_q <= S_PUSH_CHK;
						end
						CL_ADJUST: begin
							prod_s1 <= PW'(cap_q) * PW'(fsel);
							state_q <= S_CLAMP;
						end
						CL_INIT: begin
							head_q      <= '0;
							len_q       <= '0;
							marks_q     <= '0;
							any_q       <= 1'b0;
							least_q     <= LEAST_RST;
							most_q      <= '0;
							cap_q       <= hold_cap(cfg.init_cap);
							init_left_q <= init_n;
							state_q     <= S_INIT;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					if (cmp_v_s1 && match_key) begin
						found_q <= 1'b1;
						if (op_q == CL_ADD) begin
							sh_i_q  <= cmp_i_s1;
							state_q <= S_SH_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else if (cmp_v_s1 && cmp_i_s1 == len_q - LW'(1)) begin
						state_q <= (op_q == CL_ADD) ? S_PUSH_CHK : S_DONE;
					end else if (rd_i_q < len_q) begin
						cmp_v_s1 <= 1'b1;
						cmp_i_s1 <= rd_i_q;
						rd_i_q   <= rd_i_q + LW'(1);
					end
				end
				S_SH_RD: begin
					state_q <= (sh_nx < len_q) ? S_SH_WR : S_DONE;
				end
				S_SH_WR: begin
					sh_i_q  <= sh_nx;
					state_q <= S_SH_RD;
				end
				S_PUSH_CHK: begin
					// full ring: drop the head first
					if (len_q == DEPTH_L) begin
						forced_q <= 1'b1;
						state_q  <= S_POP_RD;
					end else begin
						state_q <= S_PUSH_WR;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_CMP;
				end
				S_POP_CMP: begin
					if (match_mark)
						marks_q <= marks_q - LW'(1);
					head_q    <= (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
					len_q     <= len_q - LW'(1);
					evicted_q <= evicted_q + EVICT_W'(1);
					forced_q  <= 1'b0;
					state_q   <= forced_q ? S_PUSH_WR : S_EV_CHK;
				end
				S_PUSH_WR: begin
					len_q <= len_q + LW'(1);
					if (push_val == mkey)
						marks_q <= marks_q + LW'(1);
					state_q <= (op_q == CL_ADD) ? S_EV_SET : S_REC;
				end
				S_REC: begin
					if (!any_q) begin
						least_q <= marks_c;
						most_q  <= marks_c;
						any_q   <= 1'b1;
					end else begin
						if (marks_c < least_q)
							least_q <= marks_c;
						if (marks_c > most_q)
							most_q <= marks_c;
					end
					state_q <= S_DONE;
				end
				S_EV_SET: begin
					ev_target_q <= tgt;
					state_q     <= S_EV_CHK;
				end
				S_EV_CHK: begin
					if (evicted_q < ev_target_q && len_q != '0)
						state_q <= S_POP_RD;
					else
						state_q <= S_DONE;
				end
				S_CLAMP: begin
					cap_q   <= cap_new;
					any_q   <= 1'b0;
					least_q <= LEAST_RST;
					most_q  <= '0;
					state_q <= S_EV_SET;
				end
				S_INIT: begin
					if (init_left_q != '0) begin
						len_q       <= len_q + LW'(1);
						marks_q     <= marks_q + LW'(1);
						init_left_q <= init_left_q - MARKS_W'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					found_o_q   <= found_q;
					live_o_q    <= CNT_W'(len_q - marks_q);
					marks_o_q   <= CNT_W'(marks_q);
					cap_o_q     <= cap_q;
					evicted_o_q <= evicted_q;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (recount_set)
				recount_q <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_o_q;
	assign live_count   = live_o_q;
	assign marks_held   = marks_o_q;
	assign capacity_now = cap_o_q;
	assign evicted      = evicted_o_q;

endmodule

// ----- design/dead_nonce_fifo_adaptive_core.sv -----
// channel  | handshake            | payload
// in       | in_valid / in_stall  | opcode, entry_key
// out      | out_valid / out_stall| found, live_count, marks_held, capacity_now, evicted
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Per item: query and add scan the ring one entry a cycle through the single
// read port; an add that hits moves each later entry toward the head and puts the key at the
// tail; a pop reads the head, then checks it for a marker; init writes one marker a cycle;
// adjust rescales capacity and evicts. The first item after a mark_key write recounts markers.
// Reset clears all control state at once; the key memory needs no clearing pass.
// A two-word queue takes items while the back end works or a result waits on out_stall.
module dead_nonce_fifo_adaptive_core #(
	parameter int DEPTH    = dnf_pkg::DEPTH_DEF,
	parameter int KEY_BITS = dnf_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dnf_pkg::OP_W-1:0]       opcode,
	input  logic [KEY_BITS-1:0]            entry_key,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic [dnf_pkg::CNT_W-1:0]      live_count,
	output logic [dnf_pkg::CNT_W-1:0]      marks_held,
	output logic [dnf_pkg::CNT_W-1:0]      capacity_now,
	output logic [dnf_pkg::EVICT_W-1:0]    evicted,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dnf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dnf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dnf_pkg::*;

	cfg_t                cfg_q;
	logic                cfg_wr;
	logic                recount_set;
	logic                q_valid;
	logic [2:0]          q_cls;
	logic [KEY_BITS-1:0] q_key;
	logic                q_take;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign recount_set = cfg_wr && (cfg_index == REG_MARK_KEY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_cap   <= CNT_W'(256);
			cfg_q.max_cap   <= CNT_W'(4096);
			cfg_q.init_cap  <= CNT_W'(1024);
			cfg_q.exp_marks <= MARKS_W'(5);
			cfg_q.grow      <= GROW_W'(1229);
			cfg_q.shrink    <= SHRINK_W'(922);
			cfg_q.evict_lim <= EVICT_W'(64);
			cfg_q.mark_key  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_MIN_CAP:   cfg_q.min_cap   <= cfg_data[CNT_W-1:0];
				REG_MAX_CAP:   cfg_q.max_cap   <= cfg_data[CNT_W-1:0];
				REG_INIT_CAP:  cfg_q.init_cap  <= cfg_data[CNT_W-1:0];
				REG_EXP_MARKS: cfg_q.exp_marks <= cfg_data[MARKS_W-1:0];
				REG_GROW:      cfg_q.grow      <= cfg_data[GROW_W-1:0];
				REG_SHRINK:    cfg_q.shrink    <= cfg_data[SHRINK_W-1:0];
				REG_EVICT_LIM: cfg_q.evict_lim <= cfg_data[EVICT_W-1:0];
				REG_MARK_KEY:  cfg_q.mark_key  <= cfg_data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	dnf_front #(
		.KEY_BITS (KEY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.entry_key (entry_key),
		.q_valid   (q_valid),
		.q_cls     (q_cls),
		.q_key     (q_key),
		.q_take    (q_take)
	);

	dnf_back #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.recount_set  (recount_set),
		.q_valid      (q_valid),
		.q_cls        (q_cls),
		.q_key        (q_key),
		.q_take       (q_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.live_count   (live_count),
		.marks_held   (marks_held),
		.capacity_now (capacity_now),
		.evicted      (evicted)
	);

endmodule

// ----- design/dnf_chk.sv -----
module dnf_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_ready,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        found,
	input logic [dnf_pkg::CNT_W-1:0]   live_count,
	input logic [dnf_pkg::CNT_W-1:0]   marks_held,
	input logic [dnf_pkg::CNT_W-1:0]   capacity_now,
	input logic [dnf_pkg::EVICT_W-1:0] evicted
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(live_count)
			&& $stable(marks_held) && $stable(capacity_now) && $stable(evicted))
		else $error("stalled result changed");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	a_cap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> capacity_now != '0)
		else $error("capacity reported as zero");

	// a hit means the ring holds at least one entry
	a_hit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> (live_count != '0 || marks_held != '0))
		else $error("hit reported on an empty ring");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind dead_nonce_fifo_adaptive_core dnf_chk u_dnf_chk (.*);
